FILE: rtl/core/apm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Approximate pattern matcher package
// Shared types and constants for the matcher core, its cells and its counter.
// ----------------------------------------------------------------------------
package apm_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CHARS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERRORS     = 2'd2;

  localparam int LENGTH_W = 4;
  localparam int ERRORS_W = 2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Control that travels with an item along the cell chain.
  typedef struct packed {
    logic start;
    logic hit;
  } apm_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/apm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matcher cell
// Holds the prefix-match row for one error count and updates it for each
// item, using the row of the cell before it; passes the item on a stage.
// ----------------------------------------------------------------------------
module apm_cell
  import apm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int INDEX = 0,
  parameter int POS_W = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ERRORS_W-1:0] err_sel,
  input  logic [POS_W-1:0]    last_pos,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WIDTH-1:0]    in_b,
  input  apm_ctl_t            in_ctl,
  input  logic [WIDTH-1:0]    in_row,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WIDTH-1:0]    out_b,
  output apm_ctl_t            out_ctl,
  output logic [WIDTH-1:0]    out_row
);

  localparam logic [63:0]      LOW_OWN   = (64'd1 << INDEX) - 64'd1;
  localparam logic [WIDTH-1:0] OWN_INIT  = WIDTH'(LOW_OWN);
  localparam logic [WIDTH-1:0] PREV_INIT = WIDTH'(LOW_OWN >> 1);
  localparam logic [WIDTH-1:0] ONE       = (INDEX > 0) ? WIDTH'(1) : '0;

  logic             acc;
  logic [WIDTH-1:0] row;
  logic [WIDTH-1:0] prev_copy;
  logic [WIDTH-1:0] own_old;
  logic [WIDTH-1:0] prev_old;
  logic [WIDTH-1:0] row_next;
  logic             hit_next;

  assign in_ready = ~out_valid | out_ready;
  assign acc      = in_valid & in_ready;

  // The first cell sees an all-zero row from its left, so the error terms
  // vanish there and only the exact match term remains.
  always_comb begin
    own_old  = in_ctl.start ? OWN_INIT : row;
    prev_old = in_ctl.start ? PREV_INIT : prev_copy;
    row_next = (((own_old << 1) | WIDTH'(1)) & in_b)
             | prev_old | (prev_old << 1) | ONE
             | (in_row << 1) | in_row;
    hit_next = (err_sel == INDEX) ? row_next[last_pos] : in_ctl.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row       <= OWN_INIT;
      prev_copy <= PREV_INIT;
    end else begin
      if (acc) begin
        row       <= row_next;
        prev_copy <= in_row;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_b         <= in_b;
      out_ctl.start <= in_ctl.start;
      out_ctl.hit   <= hit_next;
      out_row       <= row_next;
    end
  end

`ifndef ASSERT_OFF
  generate
    if (INDEX > 0) begin : g_chk
      // A row that allows errors always matches an empty-prefix step.
      a_low_bit: assert property (@(posedge clk) disable iff (rst)
        out_valid |-> out_row[0])
        else $error("error row lost its lowest bit");
      // Allowing one more error never removes a prefix match.
      a_superset: assert property (@(posedge clk) disable iff (rst)
        acc |=> (($past(in_row) & ~out_row) == '0))
        else $error("error row is not a superset of the row before it");
    end
  endgenerate
`endif

endmodule
`default_nettype wire

FILE: rtl/core/apm_count.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Matcher counter stage
// Keeps the saturating count of pattern ends in the current text and holds
// the result item until the receiving side takes it.
// ----------------------------------------------------------------------------
module apm_count
  import apm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  apm_ctl_t    in_ctl,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        match_here,
  output logic [31:0] match_total
);

  logic        acc;
  logic [31:0] base;
  logic [31:0] count_next;

  assign in_ready = ~out_valid | out_ready;
  assign acc      = in_valid & in_ready;

  always_comb begin
    base = in_ctl.start ? '0 : match_total;
    if (in_ctl.hit && (base != COUNT_MAX)) begin
      count_next = base + 32'd1;
    end else begin
      count_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      match_total <= '0;
    end else begin
      if (acc) begin
        match_total <= count_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      match_here <= in_ctl.hit;
    end
  end

`ifndef ASSERT_OFF
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && match_here) |-> (match_total != '0))
    else $error("match reported with a zero total");
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && !in_ctl.start) |=> (match_total >= $past(match_total)))
    else $error("match total went backwards within a text");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/approximate_pattern_matcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Approximate pattern matcher core
// Bit-parallel approximate string matching over a chain of error-row cells.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while not stalled; each item passes one
// cell stage for each error row, each cell updating its row from the new row
// of the cell before it, and then the saturating counter register that holds
// the result. A stall on the result side is absorbed by empty stages before
// it reaches the text side.
// Configuration may be written only when no item is in flight.
module approximate_pattern_matcher_core
  import apm_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int ERRORS_MAX  = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  logic [7:0]             text_char,
  input  logic                   start_of_text,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   match_here,
  output logic [31:0]            match_total
);

  localparam int ROWS  = ERRORS_MAX + 1;
  localparam int POS_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [63:0]         pattern_chars;
  logic [LENGTH_W-1:0] pattern_length;
  logic [ERRORS_W-1:0] max_errors;

  logic [POS_W-1:0]       last_pos;
  logic [ERRORS_W-1:0]    err_sel;
  logic [PATTERN_MAX-1:0] b;

  logic                   valid_c [ROWS+1];
  logic                   ready_c [ROWS+1];
  logic [PATTERN_MAX-1:0] b_c     [ROWS+1];
  logic [PATTERN_MAX-1:0] row_c   [ROWS+1];
  apm_ctl_t               ctl_c   [ROWS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars  <= '0;
      pattern_length <= LENGTH_W'(1);
      max_errors     <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_PATTERN_CHARS:  pattern_chars  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LENGTH_W-1:0];
        REG_MAX_ERRORS:     max_errors     <= cfg_data[ERRORS_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped to the nearest usable value.
  always_comb begin
    if (pattern_length == '0) begin
      last_pos = '0;
    end else if (pattern_length > PATTERN_MAX) begin
      last_pos = POS_W'(PATTERN_MAX - 1);
    end else begin
      last_pos = POS_W'(pattern_length - LENGTH_W'(1));
    end
    if (max_errors > ERRORS_MAX) begin
      err_sel = ERRORS_W'(ERRORS_MAX);
    end else begin
      err_sel = max_errors;
    end
  end

  // Character mask: positions past the register compare against a zero byte.
  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_mask
      if (k < 8) begin : g_reg
        assign b[k] = (POS_W'(k) <= last_pos) && (pattern_chars[8*k +: 8] == text_char);
      end else begin : g_zero
        assign b[k] = (POS_W'(k) <= last_pos) && (text_char == 8'd0);
      end
    end
  endgenerate

  assign valid_c[0]     = text_valid;
  assign text_stall     = ~ready_c[0];
  assign b_c[0]         = b;
  assign row_c[0]       = '0;
  assign ctl_c[0].start = start_of_text;
  assign ctl_c[0].hit   = 1'b0;

  genvar j;
  generate
    for (j = 0; j < ROWS; j++) begin : g_cell
      apm_cell #(
        .WIDTH (PATTERN_MAX),
        .INDEX (j),
        .POS_W (POS_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .err_sel   (err_sel),
        .last_pos  (last_pos),
        .in_valid  (valid_c[j]),
        .in_ready  (ready_c[j]),
        .in_b      (b_c[j]),
        .in_ctl    (ctl_c[j]),
        .in_row    (row_c[j]),
        .out_valid (valid_c[j+1]),
        .out_ready (ready_c[j+1]),
        .out_b     (b_c[j+1]),
        .out_ctl   (ctl_c[j+1]),
        .out_row   (row_c[j+1])
      );
    end
  endgenerate

  apm_count u_count (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (valid_c[ROWS]),
    .in_ready    (ready_c[ROWS]),
    .in_ctl      (ctl_c[ROWS]),
    .out_valid   (result_valid),
    .out_ready   (~result_stall),
    .match_here  (match_here),
    .match_total (match_total)
  );

`ifndef ASSERT_OFF
  a_stall_path: assert property (@(posedge clk) disable iff (rst)
    !result_stall |-> !text_stall)
    else $error("text side stalled while the result side is free");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_approximate_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// Approximate pattern matcher core testbench
// Streams text bytes through the matcher under several pattern settings and
// idle patterns, predicts every match flag and running count with a
// bit-parallel model of its own, and compares each result item in order.
// ----------------------------------------------------------------------------
module tb_approximate_pattern_matcher_core
  import apm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX = 8;
  localparam int ERRORS_MAX  = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
  } text_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] total;
  } match_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   text_valid = 1'b0;
  logic                   text_stall;
  logic [7:0]             text_char = 8'h00;
  logic                   start_of_text = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   match_here;
  logic [31:0]            match_total;

  approximate_pattern_matcher_core #(
    .PATTERN_MAX(PATTERN_MAX),
    .ERRORS_MAX (ERRORS_MAX)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .text_valid      (text_valid),
    .text_stall      (text_stall),
    .text_char       (text_char),
    .start_of_text   (start_of_text),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .match_here      (match_here),
    .match_total     (match_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pending text items, expected match results and the run's bookkeeping.
  text_item_t    text_q[$];
  match_result_t match_q[$];
  int            queued_items = 0;
  int            fails = 0;
  int            sender_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  bit            item_taken = 1'b0;
  logic [7:0]    alph[3];

  // Predictor copy of the configuration and of the match rows.
  logic [63:0]            pat_cfg = '0;
  logic [LENGTH_W-1:0]    len_cfg = 4'd1;
  logic [ERRORS_W-1:0]    err_cfg = '0;
  logic [PATTERN_MAX-1:0] rows[ERRORS_MAX+1];
  logic [31:0]            total = '0;

  task automatic flag_mismatch(input string what);
    fails++;
    if (fails <= 50) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  function automatic void clear_rows();
    for (int j = 0; j <= ERRORS_MAX; j++) begin
      rows[j] = PATTERN_MAX'((64'd1 << j) - 64'd1);
    end
  endfunction

  function automatic int pattern_span();
    if (len_cfg == 0) return 1;
    if (len_cfg > PATTERN_MAX) return PATTERN_MAX;
    return int'(len_cfg);
  endfunction

  function automatic match_result_t advance_matcher(input logic [7:0] c, input logic restart);
    int                     m;
    int                     e;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] old_prev;
    logic [PATTERN_MAX-1:0] new_prev;
    logic [PATTERN_MAX-1:0] old_cur;
    logic [PATTERN_MAX-1:0] v;
    match_result_t          r;
    m = pattern_span();
    e = (err_cfg > ERRORS_MAX) ? ERRORS_MAX : int'(err_cfg);
    if (restart) begin
      clear_rows();
      total = '0;
    end
    eq = '0;
    for (int k = 0; k < m; k++) begin
      // Positions beyond the 64-bit register read as a zero byte.
      if (((k < 8) ? pat_cfg[8*k +: 8] : 8'h00) == c) eq[k] = 1'b1;
    end
    old_prev = rows[0];
    new_prev = ((rows[0] << 1) | PATTERN_MAX'(1)) & eq;
    rows[0] = new_prev;
    for (int j = 1; j <= ERRORS_MAX; j++) begin
      old_cur = rows[j];
      v = ((old_cur << 1) | PATTERN_MAX'(1)) & eq;
      v = v | old_prev | (old_prev << 1) | PATTERN_MAX'(1) | (new_prev << 1) | new_prev;
      rows[j] = v;
      old_prev = old_cur;
      new_prev = v;
    end
    r.hit = rows[e][m-1];
    if (r.hit && total != COUNT_MAX) total = total + 32'd1;
    r.total = total;
    return r;
  endfunction

  // Sender: presents the head of the queue, holding it until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (!text_valid || item_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        text_valid    <= 1'b1;
        text_char     <= text_q[0].ch;
        start_of_text <= text_q[0].restart;
      end else begin
        text_valid <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off while one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every accepted text item is predicted at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && text_valid && !text_stall) begin
      void'(text_q.pop_front());
      match_q.push_back(advance_matcher(text_char, start_of_text));
      item_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    match_result_t r;
    if (!rst && result_valid && !result_stall) begin
      if (match_q.size() == 0) begin
        flag_mismatch("result item with no text item outstanding");
      end else begin
        r = match_q.pop_front();
        if (match_here !== r.hit) begin
          flag_mismatch($sformatf("match_here %0b, predicted %0b", match_here, r.hit));
        end
        if (match_total !== r.total) begin
          flag_mismatch($sformatf("match_total %0d, predicted %0d", match_total, r.total));
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] ch, input logic restart);
    text_item_t it;
    it.ch = ch;
    it.restart = restart;
    text_q.push_back(it);
    queued_items++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= data;
    case (idx)
      REG_PATTERN_CHARS:  pat_cfg = data;
      REG_PATTERN_LENGTH: len_cfg = data[LENGTH_W-1:0];
      REG_MAX_ERRORS:     err_cfg = data[ERRORS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || match_q.size() != 0) @(negedge clk);
    repeat (ERRORS_MAX + 4) @(negedge clk);
  endtask

  function automatic logic [7:0] text_noise();
    if ($urandom_range(3) != 0) return alph[$urandom_range(2)];
    return 8'($urandom_range(255));
  endfunction

  // Texts built from pattern occurrences carrying random edits, with
  // bytes from the pattern's alphabet and some fully random bytes between.
  task automatic queue_texts(input int n_items);
    int first;
    int text_end;
    int op;
    first = queued_items;
    while (queued_items - first < n_items) begin
      text_end = queued_items + $urandom_range(1, 30);
      // Now and then a text runs on without a restart.
      push_item(text_noise(), $urandom_range(9) != 0);
      while (queued_items < text_end) begin
        if ($urandom_range(2) != 0) begin
          push_item(text_noise(), 1'b0);
        end else begin
          for (int k = 0; k < pattern_span(); k++) begin
            op = $urandom_range(11);
            if (op == 0) begin
              push_item(text_noise(), 1'b0);
            end else if (op != 1) begin
              if (op == 2) push_item(text_noise(), 1'b0);
              push_item(pat_cfg[8*k +: 8], 1'b0);
            end
          end
        end
      end
    end
  endtask

  initial begin
    logic [63:0] pat;
    int          len;
    clear_rows();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Settings as left by reset: a one-byte pattern of zero, no errors.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    wait_drained();

    // Full-length pattern holding both extreme byte values, exact match.
    write_reg(REG_PATTERN_CHARS, {8'hFF, 8'h00, "fedcba"});
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    push_item("a", 1'b1);
    push_item("b", 1'b0);
    push_item("c", 1'b0);
    push_item("d", 1'b0);
    push_item("e", 1'b0);
    push_item("f", 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    wait_drained();

    // One edit allowed: substitution, insertion and deletion in turn.
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    write_reg(REG_MAX_ERRORS, 64'd1);
    push_item("a", 1'b1);
    push_item("x", 1'b0);
    push_item("c", 1'b0);
    push_item("a", 1'b1);
    push_item("b", 1'b0);
    push_item("x", 1'b0);
    push_item("c", 1'b0);
    push_item("a", 1'b1);
    push_item("c", 1'b0);
    wait_drained();

    // A zero length acts as one; rows carry on across the change.
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_MAX_ERRORS, 64'd0);
    push_item("a", 1'b0);
    wait_drained();

    // Length above the maximum acts as the maximum, with all errors allowed.
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_MAX_ERRORS, 64'd3);
    push_item("q", 1'b1);
    push_item("a", 1'b0);
    wait_drained();

    // More errors allowed than pattern bytes: every byte matches.
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    push_item("z", 1'b1);
    push_item(8'h80, 1'b0);
    wait_drained();

    for (int s = 0; s < 16; s++) begin
      case (s % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 85; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 85; end
        default: begin sender_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int i = 0; i < 3; i++) begin
        alph[i] = (s == 1) ? 8'h00 : (s == 2) ? 8'hFF : 8'($urandom_range(255));
      end
      for (int k = 0; k < 8; k++) begin
        pat[8*k +: 8] = ($urandom_range(7) == 0 && s > 2) ? 8'($urandom_range(255))
                                                           : alph[$urandom_range(2)];
      end
      case (s)
        0: len = 8;
        1: len = 1;
        2: len = 0;
        3: len = 15;
        default: len = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
      endcase
      write_reg(REG_PATTERN_CHARS, pat);
      write_reg(REG_PATTERN_LENGTH, 64'(len));
      write_reg(REG_MAX_ERRORS, (s < 4) ? 64'(s) : 64'($urandom_range(3)));
      queue_texts(125);
      if (s == 4) begin
        // Hold the result side long enough for the core to back up onto
        // the text side while items keep being offered.
        @(posedge clk);
        hold_left = 300;
      end
      wait_drained();
    end

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/apm_pkg.sv
rtl/core/apm_cell.sv
rtl/core/apm_count.sv
rtl/core/approximate_pattern_matcher_core.sv
sim/tb_approximate_pattern_matcher_core.sv
